@@ rtl/core/cxpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cxpd_pkg
// Shared types and codes for the chained XOR packet decoder: the item
// opcodes, the input item record and the result record.
// ----------------------------------------------------------------------------
package cxpd_pkg;

   // Width of every byte-wide field and chain register.
   localparam int ByteWidth = 8;

   typedef logic [ByteWidth-1:0] byte_type;

   // Item opcodes.
   localparam logic OP_HEADER  = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Reset value of the position counter (positions are 1-based).
   localparam byte_type POS_FIRST = byte_type'(1);

   // Packet key after reset.
   localparam byte_type PACKET_KEY_RESET = '0;

   // One input item as it sits in the input register.
   typedef struct packed {
      logic     opcode;
      byte_type rand_key;
      byte_type check_sum;
      byte_type cipher_byte;
      logic     last;
   } item_type;

   // One result item as it sits in the result register.
   typedef struct packed {
      byte_type plain_byte;
      logic     byte_valid;
      logic     packet_done;
      logic     checksum_ok;
   } result_type;

endpackage

@@ rtl/core/chained_xor_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// chained_xor_packet_decoder
// Deciphers packet payload bytes protected by a two-layer chained XOR and
// checks the payload byte sum against the sum carried in the header.
//
//   Channel  Ports                      Direction  Transfer when
//   req      req_valid / req_stall      in         valid high, stall low
//   rsp      rsp_valid / rsp_stall      out        valid high, stall low
//   csr      csr_wr_en / csr_wr_data    in         write enable high
//
// One item is accepted every cycle while req_stall is low; the input register
// takes it at the transfer edge, and the result register takes its result
// once the decode stage advances, which puts it on the response ports.
// The chain update is a few 8-bit adds and XORs between those registers.
// Reset is synchronous and active high; it clears the chain state, sets the
// position to one and the packet key to zero.
// A stalled result holds the decode stage, and the input register then stalls
// the request side once it is full.
// ----------------------------------------------------------------------------
module chained_xor_packet_decoder (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rand_key,
   input  logic [7:0] req_check_sum,
   input  logic [7:0] req_cipher_byte,
   input  logic       req_last,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_plain_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_packet_done,
   output logic       rsp_checksum_ok,
   // Configuration port.
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   cxpd_pkg::item_type   req_item;
   cxpd_pkg::item_type   item;
   cxpd_pkg::result_type rsp;
   logic                 item_valid;
   logic                 advance;

   // Gather the request fields into one item.
   assign req_item.opcode      = req_opcode;
   assign req_item.rand_key    = req_rand_key;
   assign req_item.check_sum   = req_check_sum;
   assign req_item.cipher_byte = req_cipher_byte;
   assign req_item.last        = req_last;

   cxpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   cxpd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   // Spread the result record over the response ports.
   assign rsp_plain_byte  = rsp.plain_byte;
   assign rsp_byte_valid  = rsp.byte_valid;
   assign rsp_packet_done = rsp.packet_done;
   assign rsp_checksum_ok = rsp.checksum_ok;

endmodule

@@ rtl/core/cxpd_in_reg.sv @@
// ----------------------------------------------------------------------------
// cxpd_in_reg
// Input register of the decoder. It holds one accepted item and releases it
// to the decode stage whenever that stage advances.
// ----------------------------------------------------------------------------
module cxpd_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cxpd_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output cxpd_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   cxpd_pkg::item_type item_ff;
   cxpd_pkg::item_type item_in;
   logic               load;

   // The register takes a new transfer when it is empty or being drained.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = req_valid;
         if (req_valid) begin
            item_in = req_item;
         end
      end
   end

   // Valid flag is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/cxpd_core.sv @@
// ----------------------------------------------------------------------------
// cxpd_core
// Decode stage: holds the packet key and chain state, deciphers one item per
// cycle unless stalled, by 8-bit adds and XORs, and loads the result register.
// ----------------------------------------------------------------------------
module cxpd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  cxpd_pkg::byte_type   csr_wr_data,
   input  logic                 item_valid,
   input  cxpd_pkg::item_type   item,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cxpd_pkg::result_type rsp
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   cxpd_pkg::result_type rsp_ff;
   cxpd_pkg::result_type rsp_in;

   cxpd_pkg::byte_type   packet_key_ff;
   cxpd_pkg::byte_type   packet_key_in;
   cxpd_pkg::byte_type   prev_plain_ff;
   cxpd_pkg::byte_type   prev_plain_in;
   cxpd_pkg::byte_type   prev_cipher_ff;
   cxpd_pkg::byte_type   prev_cipher_in;
   cxpd_pkg::byte_type   held_rand_key_ff;
   cxpd_pkg::byte_type   held_rand_key_in;
   cxpd_pkg::byte_type   expected_sum_ff;
   cxpd_pkg::byte_type   expected_sum_in;
   cxpd_pkg::byte_type   running_sum_ff;
   cxpd_pkg::byte_type   running_sum_in;
   cxpd_pkg::byte_type   position_ff;
   cxpd_pkg::byte_type   position_in;

   cxpd_pkg::byte_type   key_outer;
   cxpd_pkg::byte_type   key_inner;
   cxpd_pkg::byte_type   stage_byte;
   cxpd_pkg::byte_type   plain;
   cxpd_pkg::byte_type   header_plain;
   logic                 fire;

   // The stage moves when the result register is empty or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = advance && item_valid;

   // Packet key register, written through the configuration port.
   assign packet_key_in = csr_wr_en ? csr_wr_data : packet_key_ff;

   // Cipher keys for a payload byte; all sums wrap at 256.
   assign key_outer    = prev_cipher_ff + packet_key_ff + position_ff + 8'd1;
   assign stage_byte   = item.cipher_byte ^ key_outer;
   assign key_inner    = prev_plain_ff + held_rand_key_ff + position_ff + 8'd1;
   assign plain        = stage_byte ^ key_inner;
   assign header_plain = item.check_sum ^ (packet_key_ff + 8'd1);

   // Next chain state and next result.
   always_comb begin
      prev_plain_in    = prev_plain_ff;
      prev_cipher_in   = prev_cipher_ff;
      held_rand_key_in = held_rand_key_ff;
      expected_sum_in  = expected_sum_ff;
      running_sum_in   = running_sum_ff;
      position_in      = position_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      if (advance) begin
         rsp_valid_in = item_valid;
      end
      if (fire) begin
         case (item.opcode)
            cxpd_pkg::OP_HEADER: begin
               prev_plain_in    = header_plain;
               expected_sum_in  = header_plain ^ (item.rand_key + 8'd1);
               prev_cipher_in   = item.check_sum;
               held_rand_key_in = item.rand_key;
               running_sum_in   = '0;
               position_in      = cxpd_pkg::POS_FIRST;
               rsp_in.plain_byte = '0;
               rsp_in.byte_valid = 1'b0;
            end
            default: begin
               prev_plain_in     = stage_byte;
               prev_cipher_in    = item.cipher_byte;
               running_sum_in    = running_sum_ff + plain;
               position_in       = position_ff + 8'd1;
               rsp_in.plain_byte = plain;
               rsp_in.byte_valid = 1'b1;
            end
         endcase
         // The sum check sees the state as this item leaves it.
         rsp_in.packet_done = item.last;
         rsp_in.checksum_ok = item.last && (running_sum_in == expected_sum_in);
      end
   end

   // Control state and chain state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         packet_key_ff    <= cxpd_pkg::PACKET_KEY_RESET;
         prev_plain_ff    <= '0;
         prev_cipher_ff   <= '0;
         held_rand_key_ff <= '0;
         expected_sum_ff  <= '0;
         running_sum_ff   <= '0;
         position_ff      <= cxpd_pkg::POS_FIRST;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         packet_key_ff    <= packet_key_in;
         prev_plain_ff    <= prev_plain_in;
         prev_cipher_ff   <= prev_cipher_in;
         held_rand_key_ff <= held_rand_key_in;
         expected_sum_ff  <= expected_sum_in;
         running_sum_ff   <= running_sum_in;
         position_ff      <= position_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ dv/chained_xor_packet_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// chained_xor_packet_decoder_tb
// Self-checking testbench for the chained XOR packet decoder. A short table of
// directed items covers the reset state, empty packets, headers inside open
// packets, payload without a header and a key change within a packet. Random
// phases follow. Each phase has its own packet key. Most of the traffic is
// packets enciphered by an encoder in the bench, so that the checksum path is
// exercised, mixed with truncated packets, stray payload bytes and noise.
// A bench-side decoder predicts every result. Both channels idle at random,
// and one long response hold-off backs the block up into its request side.
// ----------------------------------------------------------------------------
module chained_xor_packet_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_ROWS    = 20;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 32;
   localparam int LONG_BYTES  = 257;
   localparam int LONG_HOLD   = 40;

   // One directed row: an optional key write ahead of the item, the item
   // itself and, where it is obvious, the result typed in by hand.
   typedef struct packed {
      logic                 key_wr;
      cxpd_pkg::byte_type   key;
      cxpd_pkg::item_type   it;
      logic                 typed;
      cxpd_pkg::result_type res;
   } dir_row_type;

   localparam dir_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // Payload straight after reset uses the reset chain state.
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
        '{8'h00, 1'b1, 1'b0, 1'b0}},
      // Empty packets, one with a nonzero and one with a zero header sum.
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'hFF, 8'h01, 8'hFF, 1'b1}, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b1}},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hA5, 1'b1}, 1'b0, '0},
      // Payload after a finished packet continues the chain.
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 8'h5A, 1'b1}, 1'b0, '0},
      // A header inside an open packet drops it and starts over.
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'h3C, 8'hC3, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h12, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'h81, 8'h7E, 8'hFF, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
      // The key changes while the packet is still open.
      '{1'b1, 8'hFF, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h80, 1'b1}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_HEADER, 8'h55, 8'hAA, 8'h00, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h01, 1'b0}, 1'b0, '0},
      '{1'b0, 8'h00, '{cxpd_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h7F, 1'b1}, 1'b0, '0},
      '{1'b1, 8'h01, '{cxpd_pkg::OP_HEADER, 8'hFE, 8'h01, 8'h00, 1'b1}, 1'b0, '0}
   };

   // Block ports.
   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic       req_opcode      = 1'b0;
   logic [7:0] req_rand_key    = 8'h00;
   logic [7:0] req_check_sum   = 8'h00;
   logic [7:0] req_cipher_byte = 8'h00;
   logic       req_last        = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_plain_byte;
   logic       rsp_byte_valid;
   logic       rsp_packet_done;
   logic       rsp_checksum_ok;
   logic       csr_wr_en       = 1'b0;
   logic [7:0] csr_wr_data     = 8'h00;

   // A hand-typed expectation travels with the item that carries it.
   logic                 req_typed     = 1'b0;
   cxpd_pkg::result_type req_typed_res = '0;

   // Bench-side copy of the decoder state and of its key register.
   cxpd_pkg::byte_type   model_key    = cxpd_pkg::PACKET_KEY_RESET;
   cxpd_pkg::byte_type   chain_plain  = '0;
   cxpd_pkg::byte_type   chain_cipher = '0;
   cxpd_pkg::byte_type   hdr_rand_key = '0;
   cxpd_pkg::byte_type   hdr_sum      = '0;
   cxpd_pkg::byte_type   byte_sum     = '0;
   cxpd_pkg::byte_type   byte_pos     = cxpd_pkg::POS_FIRST;

   cxpd_pkg::result_type expected_results [$];
   cxpd_pkg::item_type   seq_items [$];

   cxpd_pkg::byte_type   cur_key        = cxpd_pkg::PACKET_KEY_RESET;
   int                   max_req_gap    = 5;
   int                   max_rsp_stall  = 5;
   bit                   long_hold_req  = 1'b0;
   int                   error_count    = 0;
   int                   cycle_count    = 0;
   int                   results_seen   = 0;
   int                   good_packets   = 0;
   int                   bad_packets    = 0;
   int                   key_settings   = 0;
   int                   random_items   = 0;
   int                   phase_items    = 0;

   chained_xor_packet_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_rand_key    (req_rand_key),
      .req_check_sum   (req_check_sum),
      .req_cipher_byte (req_cipher_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_plain_byte  (rsp_plain_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_packet_done (rsp_packet_done),
      .rsp_checksum_ok (rsp_checksum_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Deciphers one item with the bench copy of the chain state and returns
   // the result the block should give for it.
   function automatic cxpd_pkg::result_type decipher_item(input cxpd_pkg::item_type it);
      cxpd_pkg::result_type r;
      cxpd_pkg::byte_type   t;
      r = '0;
      if (it.opcode == cxpd_pkg::OP_HEADER) begin
         chain_plain  = it.check_sum ^ cxpd_pkg::byte_type'(model_key + 8'd1);
         hdr_sum      = chain_plain ^ cxpd_pkg::byte_type'(it.rand_key + 8'd1);
         chain_cipher = it.check_sum;
         hdr_rand_key = it.rand_key;
         byte_sum     = '0;
         byte_pos     = cxpd_pkg::POS_FIRST;
      end else begin
         t = it.cipher_byte ^
             cxpd_pkg::byte_type'(chain_cipher + model_key + byte_pos + 8'd1);
         r.plain_byte = t ^
             cxpd_pkg::byte_type'(chain_plain + hdr_rand_key + byte_pos + 8'd1);
         r.byte_valid = 1'b1;
         chain_plain  = t;
         chain_cipher = it.cipher_byte;
         byte_sum     = cxpd_pkg::byte_type'(byte_sum + r.plain_byte);
         byte_pos     = cxpd_pkg::byte_type'(byte_pos + 8'd1);
      end
      r.packet_done = it.last;
      r.checksum_ok = it.last && (byte_sum == hdr_sum);
      return r;
   endfunction

   task automatic report_field(input string name, input cxpd_pkg::byte_type want,
                               input cxpd_pkg::byte_type got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Predicts each request transfer and checks each response transfer
   // against the oldest expectation. Key writes update the bench register.
   always @(posedge clock) begin
      cxpd_pkg::result_type want;
      cxpd_pkg::result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = decipher_item('{req_opcode, req_rand_key, req_check_sum,
                                   req_cipher_byte, req_last});
            if (req_typed) begin
               want = req_typed_res;
            end
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_plain_byte, rsp_byte_valid, rsp_packet_done, rsp_checksum_ok};
            results_seen++;
            if (got.packet_done && got.checksum_ok) good_packets++;
            if (got.packet_done && !got.checksum_ok) bad_packets++;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, actual %h", $time, got);
            end else begin
               want = expected_results.pop_front();
               report_field("plain_byte", want.plain_byte, got.plain_byte);
               report_field("byte_valid", cxpd_pkg::byte_type'(want.byte_valid),
                            cxpd_pkg::byte_type'(got.byte_valid));
               report_field("packet_done", cxpd_pkg::byte_type'(want.packet_done),
                            cxpd_pkg::byte_type'(got.packet_done));
               report_field("checksum_ok", cxpd_pkg::byte_type'(want.checksum_ok),
                            cxpd_pkg::byte_type'(got.checksum_ok));
            end
         end
         if (csr_wr_en) begin
            model_key = csr_wr_data;
         end
      end
   end

   // Response side: waits a random number of cycles before each transfer,
   // or a long stretch once when asked to.
   initial begin
      int n;
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            n = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            n = $urandom_range(0, max_rsp_stall);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Offers one item after a gap and holds it until its transfer.
   task automatic send_item(input cxpd_pkg::item_type it, input logic typed,
                            input cxpd_pkg::result_type res, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid       <= 1'b0;
         req_opcode      <= 1'($urandom);
         req_rand_key    <= 8'($urandom);
         req_check_sum   <= 8'($urandom);
         req_cipher_byte <= 8'($urandom);
         req_last        <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= it.opcode;
      req_rand_key    <= it.rand_key;
      req_check_sum   <= it.check_sum;
      req_cipher_byte <= it.cipher_byte;
      req_last        <= it.last;
      req_typed       <= typed;
      req_typed_res   <= res;
      do @(posedge clock); while (req_stall);
   endtask

   // Lets every result drain, waits out the pipeline and writes a new key.
   task automatic write_key(input cxpd_pkg::byte_type key);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= key;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_key = key;
      key_settings++;
   endtask

   // Enciphers a random payload under the current key and queues the header
   // and payload items. A bad sum offsets the header checksum.
   task automatic encipher_packet(input int nbytes, input bit bad_sum);
      cxpd_pkg::byte_type plain [$];
      cxpd_pkg::byte_type total;
      cxpd_pkg::byte_type rk;
      cxpd_pkg::byte_type pp;
      cxpd_pkg::byte_type pc;
      cxpd_pkg::byte_type t;
      cxpd_pkg::byte_type pos;
      cxpd_pkg::item_type it;
      total = '0;
      for (int i = 0; i < nbytes; i++) begin
         plain.push_back(8'($urandom));
         total = cxpd_pkg::byte_type'(total + plain[i]);
      end
      if (bad_sum) total = cxpd_pkg::byte_type'(total + 8'($urandom_range(1, 255)));
      rk = 8'($urandom);
      pp = total ^ cxpd_pkg::byte_type'(rk + 8'd1);
      it.opcode      = cxpd_pkg::OP_HEADER;
      it.rand_key    = rk;
      it.check_sum   = pp ^ cxpd_pkg::byte_type'(cur_key + 8'd1);
      it.cipher_byte = 8'($urandom);
      it.last        = (nbytes == 0);
      pc = it.check_sum;
      seq_items.push_back(it);
      for (int i = 0; i < nbytes; i++) begin
         pos = cxpd_pkg::byte_type'(i + 1);
         t   = plain[i] ^ cxpd_pkg::byte_type'(pp + rk + pos + 8'd1);
         it.opcode      = cxpd_pkg::OP_PAYLOAD;
         it.rand_key    = 8'($urandom);
         it.check_sum   = 8'($urandom);
         it.cipher_byte = t ^ cxpd_pkg::byte_type'(pc + cur_key + pos + 8'd1);
         it.last        = (i == nbytes - 1);
         pp = t;
         pc = it.cipher_byte;
         seq_items.push_back(it);
      end
   endtask

   function automatic cxpd_pkg::item_type random_item();
      cxpd_pkg::item_type it;
      it.opcode      = 1'($urandom);
      it.rand_key    = 8'($urandom);
      it.check_sum   = 8'($urandom);
      it.cipher_byte = 8'($urandom);
      it.last        = 1'($urandom);
      return it;
   endfunction

   // Sends the queued sequence with random gaps.
   task automatic send_seq();
      foreach (seq_items[i]) begin
         send_item(seq_items[i], 1'b0, '0, $urandom_range(0, max_req_gap));
         phase_items++;
         random_items++;
      end
      seq_items.delete();
   endtask

   // Main sequence: reset, directed table, random phases, drain, verdict.
   initial begin
      int                 kind;
      int                 n;
      cxpd_pkg::item_type it;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED_ROWS[r].key_wr) write_key(DIRECTED_ROWS[r].key);
         send_item(DIRECTED_ROWS[r].it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res,
                   $urandom_range(0, max_req_gap));
      end

      // Random phases, each under its own key and idling profile.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 0) write_key(8'hFF);
         else if (phase == 1) write_key(8'h00);
         else write_key(8'($urandom));
         max_req_gap   = (phase == 2 || phase == 5) ? 0 : 5;
         max_rsp_stall = (phase == 3 || phase == 5) ? 0 : 5;
         if (phase == 2) long_hold_req = 1'b1;
         phase_items = 0;
         // A packet long enough to wrap the position counter.
         if (phase == NUM_PHASES - 1) begin
            encipher_packet(LONG_BYTES, 1'b0);
            send_seq();
         end
         while (phase_items < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
               encipher_packet(n, $urandom_range(0, 5) == 0);
            end else if (kind < 80) begin
               // Truncated packet; the next header drops what is left open.
               encipher_packet($urandom_range(2, 6), 1'b0);
               repeat ($urandom_range(1, seq_items.size() - 1)) void'(seq_items.pop_back());
            end else begin
               // Stray payload bytes, or pure noise.
               repeat ($urandom_range(1, 4)) begin
                  it = random_item();
                  if (kind < 90) it.opcode = cxpd_pkg::OP_PAYLOAD;
                  seq_items.push_back(it);
               end
            end
            send_seq();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d directed rows and %0d random items under %0d key settings,",
               NUM_ROWS, random_items, key_settings);
      $display("with %0d results checked: %0d packets summed correctly, %0d did not.",
               results_seen, good_packets, bad_packets);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/cxpd_pkg.sv
rtl/core/cxpd_in_reg.sv
rtl/core/cxpd_core.sv
rtl/core/chained_xor_packet_decoder.sv
dv/chained_xor_packet_decoder_tb.sv
